// File: rtl/pcwm_pkg.sv
// ----------------------------------------------------------------------------
// pcwm_pkg
// Shared types and constants for the per-channel windowed mean block.
// ----------------------------------------------------------------------------
package pcwm_pkg;

  localparam int NUM_CHANNELS = 1024;
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_BITS   = 16;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int ADDR_W       = CH_W + 1;
  localparam int SUM_W        = 32;
  localparam int TIME_W       = 63;
  localparam int FRAC_W       = 4;
  localparam int QUO_W        = SUM_W + FRAC_W;
  localparam int STEP_W       = $clog2(QUO_W);
  localparam int MEAN_W       = 20;
  localparam int HIT_W        = 16;
  localparam int ENTRY_W      = 1 + COUNT_BITS + SUM_W;
  localparam logic [31:0] WINDOW_RESET = 32'd30;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic KIND_NOTICE  = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [9:0]        channel;
    logic [15:0]       baseline;
    logic [TIME_W-1:0] event_time;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [TIME_W-1:0] window_start;
    logic [9:0]        channel_out;
    logic [MEAN_W-1:0] mean_q4;
    logic [HIT_W-1:0]  hit_total;
    logic              saturated;
  } result_t;

  typedef struct packed {
    logic accept;
    logic add_wr;
    logic div_load;
    logic div_step;
    logic emit;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic close_hit;
    logic clr_done;
    logic cnt_zero;
    logic div_last;
  } status_t;

endpackage

// File: rtl/pcwm_ctrl.sv
// ----------------------------------------------------------------------------
// pcwm_ctrl
// Sequencer: sample update, window close and bank clear, divide and readout.
// ----------------------------------------------------------------------------
module pcwm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       op,
  input  pcwm_pkg::status_t status,
  output logic             busy,
  output pcwm_pkg::cmd_t    cmd
);
  import pcwm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ADD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_DIV   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_CLEAR = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (op)
            OP_ADD:   state_next = S_ADD;
            OP_EVENT: state_next = status.close_hit ? S_CLEAR : S_IDLE;
            OP_READ:  state_next = S_LOAD;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd.add_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = status.cnt_zero ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/pcwm_datapath.sv
// ----------------------------------------------------------------------------
// pcwm_datapath
// Two-bank sum/count memory, window timing, serial divider, result register.
// ----------------------------------------------------------------------------
module pcwm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pcwm_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  pcwm_pkg::cmd_t    cmd,
  output pcwm_pkg::status_t status,
  output logic              done,
  output pcwm_pkg::result_t result
);
  import pcwm_pkg::*;

  logic [ENTRY_W-1:0] mem [2*NUM_CHANNELS];
  logic [ENTRY_W-1:0] mem_q;
  logic [ENTRY_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr, wr_addr, op_addr;
  logic               wr_en;

  logic [31:0]        window_length;
  logic               bank;
  logic               started;
  logic [TIME_W-1:0]  window_begin;
  logic [TIME_W-1:0]  closed_begin;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               clr_full;

  logic [QUO_W-1:0]      quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] den;
  logic [STEP_W-1:0]     step;
  logic                  r_sat;
  logic [CH_W-1:0]       r_ch;
  logic [SAMPLE_BITS-1:0] r_smp;

  logic [SUM_W-1:0]      q_sum;
  logic [COUNT_BITS-1:0] q_cnt;
  logic                  q_sat;
  logic [SUM_W:0]        sum_ext;
  logic [COUNT_BITS:0]   cnt_ext;
  logic [TIME_W-1:0]     t_diff;
  logic                  close_cond;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;

  assign {q_sat, q_cnt, q_sum} = mem_q;
  assign sum_ext = {1'b0, q_sum} + {{(SUM_W+1-SAMPLE_BITS){1'b0}}, r_smp};
  assign cnt_ext = {1'b0, q_cnt} + {{COUNT_BITS{1'b0}}, 1'b1};

  assign t_diff     = item.event_time - window_begin;
  assign close_cond = started && (item.event_time > window_begin) &&
                      (t_diff > {{(TIME_W-32){1'b0}}, window_length});

  assign rd_addr = {(item.op == OP_READ) ? ~bank : bank, item.channel[CH_W-1:0]};
  assign wr_en   = cmd.add_wr | cmd.clr_step;
  assign wr_addr = cmd.clr_step ? clr_cnt : op_addr;
  assign wr_data = cmd.clr_step ? '0 :
                   {q_sat | sum_ext[SUM_W] | cnt_ext[COUNT_BITS],
                    cnt_ext[COUNT_BITS] ? {COUNT_BITS{1'b1}} : cnt_ext[COUNT_BITS-1:0],
                    sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0]};

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  assign rem_sh = {rem, quo[QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  assign status.close_hit = (item.op == OP_EVENT) && close_cond;
  assign status.clr_done  = (&clr_cnt[CH_W-1:0]) && (clr_cnt[CH_W] || !clr_full);
  assign status.cnt_zero  = (q_cnt == '0);
  assign status.div_last  = (step == STEP_W'(QUO_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      bank          <= 1'b0;
      started       <= 1'b0;
      window_begin  <= '0;
      closed_begin  <= '0;
      clr_cnt       <= '0;
      clr_full      <= 1'b1;
      done          <= 1'b0;
    end else begin
      done <= cmd.emit | (cmd.accept & status.close_hit);
      if (cfg_we) window_length <= cfg_wdata;
      if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.accept && item.op == OP_EVENT) begin
        if (!started) begin
          started      <= 1'b1;
          window_begin <= item.event_time;
        end else if (close_cond) begin
          bank         <= ~bank;
          closed_begin <= window_begin;
          window_begin <= item.event_time;
          clr_cnt      <= {~bank, {CH_W{1'b0}}};
          clr_full     <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_addr <= rd_addr;
      r_ch    <= item.channel[CH_W-1:0];
      r_smp   <= item.baseline[SAMPLE_BITS-1:0];
      if (item.op == OP_EVENT) begin
        result <= {KIND_NOTICE, window_begin, {(10+MEAN_W+HIT_W+1){1'b0}}};
      end
    end
    if (cmd.div_load) begin
      quo   <= {q_sum, {FRAC_W{1'b0}}};
      rem   <= '0;
      den   <= q_cnt;
      step  <= '0;
      r_sat <= q_sat;
    end
    if (cmd.div_step) begin
      rem  <= ge ? COUNT_BITS'(rem_sh - {1'b0, den}) : rem_sh[COUNT_BITS-1:0];
      quo  <= {quo[QUO_W-2:0], ge};
      step <= step + 1'b1;
    end
    if (cmd.emit) begin
      result.kind         <= KIND_READOUT;
      result.window_start <= closed_begin;
      result.channel_out  <= 10'(r_ch);
      result.mean_q4      <= (den == '0) ? '0 :
                             ((|quo[QUO_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : quo[MEAN_W-1:0]);
      result.hit_total    <= HIT_W'(den);
      result.saturated    <= r_sat;
    end
  end

endmodule

// File: rtl/per_channel_windowed_mean.sv
// ----------------------------------------------------------------------------
// per_channel_windowed_mean
// Per-channel baseline averager over time windows with a frozen read bank.
// ----------------------------------------------------------------------------
// A sample does a memory read, then an update write. An event that does
// not close the window leaves the block idle; one that closes it gives its
// notice beat on the next cycle, then stays busy clearing the new active
// bank. A read does a memory read, a 36-step serial divider and the result
// register, skipping the divider when the channel has no hits. After reset
// the block is busy clearing both banks. Results appear on done for one
// cycle; the receiver cannot stall them. window_length may be written any
// time the block is idle.
module per_channel_windowed_mean (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pcwm_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  output logic              done,
  output pcwm_pkg::result_t result
);
  import pcwm_pkg::*;

  cmd_t    cmd;
  status_t status;

  pcwm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (item.op),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  pcwm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result)
  );

endmodule

// File: rtl/pcwm_checker.sv
// ----------------------------------------------------------------------------
// pcwm_props
// Port-level checks for the per-channel windowed mean block.
// ----------------------------------------------------------------------------
module pcwm_props (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pcwm_pkg::item_t   item,
  input logic              done,
  input pcwm_pkg::result_t result
);
  import pcwm_pkg::*;

  a_reset_clear: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy clearing after reset");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.op == OP_ADD || item.op == OP_READ)) |=> busy)
    else $error("sample or read beat did not hold busy");

  a_notice_src: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_NOTICE) |-> $past(start && !busy && item.op == OP_EVENT))
    else $error("notice beat without an event");

  a_notice_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.kind == KIND_NOTICE) |->
      (result.mean_q4 == '0 && result.hit_total == '0 && result.channel_out == '0))
    else $error("notice beat carries readout fields");

endmodule

bind per_channel_windowed_mean pcwm_props u_pcwm_props (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
